@@ rtl/ap_rr_pkg.sv @@
// ----------------------------------------------------------------------------
// ap_rr_pkg
// Shared types, constants and saturating helpers for the reaction-rate pipe.
// ----------------------------------------------------------------------------
package ap_rr_pkg;

  localparam int WORD_W = 32;
  localparam int WIDE_W = 64;

  // latency of one fixed-point multiplier
  localparam int MUL_LAT = 6;

  // divider: dividend/quotient bits and divisor bits
  localparam int DIV_NW = 64;
  localparam int DIV_DW = 34;

  localparam logic signed [WIDE_W-1:0] WIDE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  // configuration register indexes
  localparam logic [2:0] REG_GAIN_K      = 3'd0;
  localparam logic [2:0] REG_THRESHOLD_A = 3'd1;
  localparam logic [2:0] REG_EPS_BASE    = 3'd2;
  localparam logic [2:0] REG_MU_ONE      = 3'd3;
  localparam logic [2:0] REG_MU_TWO      = 3'd4;

  typedef struct packed {
    logic                     clip;
    logic signed [WIDE_W-1:0] val;
  } wide_t;

  typedef struct packed {
    logic                     clip;
    logic signed [WORD_W-1:0] val;
  } word_t;

  function automatic logic signed [WIDE_W-1:0] sx32(input logic [WORD_W-1:0] x);
    return {{(WIDE_W-WORD_W){x[WORD_W-1]}}, x};
  endfunction

  // add clamped to +-(2^63-1)
  function automatic wide_t sat_add(input logic signed [WIDE_W-1:0] x,
                                    input logic signed [WIDE_W-1:0] y);
    logic signed [WIDE_W:0] s;
    logic signed [WIDE_W:0] smax;
    wide_t r;
    smax = {1'b0, WIDE_MAX};
    s = {x[WIDE_W-1], x} + {y[WIDE_W-1], y};
    r.clip = 1'b0;
    r.val = s[WIDE_W-1:0];
    if (s > smax) begin
      r.clip = 1'b1;
      r.val = WIDE_MAX;
    end else if (s < -smax) begin
      r.clip = 1'b1;
      r.val = -WIDE_MAX;
    end
    return r;
  endfunction

  function automatic word_t clip32(input logic signed [WIDE_W-1:0] x);
    word_t r;
    r.clip = 1'b0;
    r.val = x[WORD_W-1:0];
    if (x > 64'sh0000_0000_7FFF_FFFF) begin
      r.clip = 1'b1;
      r.val = 32'sh7FFF_FFFF;
    end else if (x < -64'sh0000_0000_8000_0000) begin
      r.clip = 1'b1;
      r.val = 32'sh8000_0000;
    end
    return r;
  endfunction

endpackage

@@ rtl/ap_rr_delay.sv @@
// ----------------------------------------------------------------------------
// ap_rr_delay
// Enabled shift line that keeps side values aligned with the arithmetic.
// ----------------------------------------------------------------------------
module ap_rr_delay #(
  parameter int W     = 64,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign q = tap[DEPTH-1];

endmodule

@@ rtl/ap_rr_qmul.sv @@
// ----------------------------------------------------------------------------
// ap_rr_qmul
// Six-stage signed fixed-point multiply: four 32-bit partial products,
// round half away from zero, clamp to +-(2^63-1).
// ----------------------------------------------------------------------------
module ap_rr_qmul #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [63:0]     a,
  input  logic signed [63:0]     b,
  output ap_rr_pkg::wide_t       p
);

  localparam int RW = 127 - FRAC_BITS;
  localparam logic [126:0] HALF = 127'(1) << (FRAC_BITS - 1);

  logic        neg1, neg2, neg3, neg4, neg5;
  logic [62:0] ma, mb;
  logic [63:0] p00;
  logic [62:0] p01, p10;
  logic [61:0] p11, p11_3;
  logic [64:0] mid;
  logic [31:0] lo3;
  logic [125:0] prod;
  logic        clip5;
  logic [62:0] mag;
  logic [126:0] rsum;
  logic [RW-1:0] rsh;

  always_comb begin
    rsum = {1'b0, prod} + HALF;
    rsh  = rsum[126:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= a[63] ^ b[63];
      ma   <= a[63] ? 63'(-a) : a[62:0];
      mb   <= b[63] ? 63'(-b) : b[62:0];

      neg2 <= neg1;
      p00  <= ma[31:0] * mb[31:0];
      p01  <= ma[31:0] * mb[62:32];
      p10  <= ma[62:32] * mb[31:0];
      p11  <= ma[62:32] * mb[62:32];

      neg3  <= neg2;
      mid   <= {2'b0, p01} + {2'b0, p10} + {33'b0, p00[63:32]};
      lo3   <= p00[31:0];
      p11_3 <= p11;

      neg4 <= neg3;
      prod <= {62'(p11_3 + 62'(mid[64:32])), mid[31:0], lo3};

      neg5  <= neg4;
      clip5 <= |rsh[RW-1:63];
      mag   <= (|rsh[RW-1:63]) ? '1 : rsh[62:0];

      p.clip <= clip5;
      p.val  <= neg5 ? 64'(-{1'b0, mag}) : {1'b0, mag};
    end
  end

endmodule

@@ rtl/ap_rr_div.sv @@
// ----------------------------------------------------------------------------
// ap_rr_div
// Unsigned restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module ap_rr_div (
  input  logic                              clk,
  input  logic                              en,
  input  logic [ap_rr_pkg::DIV_NW-1:0]      num,
  input  logic [ap_rr_pkg::DIV_DW-1:0]      den,
  output logic [ap_rr_pkg::DIV_NW-1:0]      quo
);

  localparam int NW = ap_rr_pkg::DIV_NW;
  localparam int DW = ap_rr_pkg::DIV_DW;

  logic [DW-1:0] rem [NW-1];
  logic [DW-1:0] dsr [NW-1];
  logic [NW-1:0] nq  [NW];

  for (genvar g = 0; g < NW; g++) begin : g_step
    logic [DW-1:0] r_in, d_in;
    logic [NW-1:0] q_in;
    logic [DW:0]   sh, diff;
    logic          take;

    if (g == 0) begin : g_first
      assign r_in = '0;
      assign q_in = num;
      assign d_in = den;
    end else begin : g_rest
      assign r_in = rem[g-1];
      assign q_in = nq[g-1];
      assign d_in = dsr[g-1];
    end

    // shift in the next dividend bit, subtract when it fits
    assign sh   = {r_in, q_in[NW-1]};
    assign take = sh >= {1'b0, d_in};
    assign diff = sh - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        nq[g] <= {q_in[NW-2:0], take};
      end
    end

    if (g < NW - 1) begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          rem[g] <= take ? diff[DW-1:0] : sh[DW-1:0];
          dsr[g] <= d_in;
        end
      end
    end
  end

  assign quo = nq[NW-1];

endmodule

@@ rtl/aliev_panfilov_reaction_rate.sv @@
// ----------------------------------------------------------------------------
// aliev_panfilov_reaction_rate
// Per-node reaction term: du = -k*u*(u-a)*(u-1) - u*v,
// dv = eps*(-v - k*u*(u-a-1)), eps = eps0 + mu1*v/(u+mu2).
// ----------------------------------------------------------------------------
// usage
//   input stream s_*: one beat per grid node, u and v in signed fixed point
//   output stream m_*: one beat per node, both rates, fault and clip flags
//   cfg_*: five coefficient registers, written while the stream is quiet
// throughput and pipeline depth
//   one node per cycle sustained while the pipe does not hold (see stall); the
//   depth comes from the 64-stage divider for mu1*v/(u+mu2), followed by one
//   6-stage multiplier for eps*inner
// reset
//   clears all valid bits and loads the default coefficients
// stall
//   the whole pipe holds while a result sits in the output register and the
//   receiver is not ready; s_tready is low only then
// ----------------------------------------------------------------------------
module aliev_panfilov_reaction_rate #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,    // [31:0] excitation, [63:32] recovery
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,    // [31:0] excitation_rate, [63:32] recovery_rate,
                                  // [64] divide_fault, [65] saturated, rest zero
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int ML      = ap_rr_pkg::MUL_LAT;
  localparam int T_PRE   = 1;
  localparam int T_KU    = ML;
  localparam int T_T1    = T_KU + ML;
  localparam int T_CUB   = T_T1 + ML;
  localparam int T_DU    = T_CUB + 1;
  localparam int T_INNER = T_T1 + 1;
  localparam int T_DIVIN = 2;
  localparam int T_Q     = T_DIVIN + ap_rr_pkg::DIV_NW;
  localparam int T_EPS   = T_Q + 2;
  localparam int T_DV    = T_EPS + ML;
  localparam int T_OUT   = T_DV + 1;

  localparam logic signed [63:0] ONE = 64'(1) << FRAC_BITS;

  logic [31:0] gain_k, threshold_a, eps_base, mu_one, mu_two;
  logic [T_OUT:0] vld;
  logic en;

  assign en       = !vld[T_OUT] || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[T_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_k      <= 32'd524288;
      threshold_a <= 32'd9830;
      eps_base    <= 32'd131;
      mu_one      <= 32'd13107;
      mu_two      <= 32'd19661;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ap_rr_pkg::REG_GAIN_K:      gain_k      <= cfg_data;
        ap_rr_pkg::REG_THRESHOLD_A: threshold_a <= cfg_data;
        ap_rr_pkg::REG_EPS_BASE:    eps_base    <= cfg_data;
        ap_rr_pkg::REG_MU_ONE:      mu_one      <= cfg_data;
        ap_rr_pkg::REG_MU_TWO:      mu_two      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[T_OUT-1:0], s_tvalid};
    end
  end

  // stage 0 and 1: capture, offsets, mu1*v and u+mu2
  logic [31:0] u0, v0;
  logic signed [63:0] ua1, uam1, um1, negv1, num1;
  logic signed [32:0] den1;

  always_ff @(posedge clk) begin
    if (en) begin
      u0    <= s_tdata[31:0];
      v0    <= s_tdata[63:32];
      ua1   <= ap_rr_pkg::sx32(u0) - ap_rr_pkg::sx32(threshold_a);
      uam1  <= ap_rr_pkg::sx32(u0) - ap_rr_pkg::sx32(threshold_a) - ONE;
      um1   <= ap_rr_pkg::sx32(u0) - ONE;
      negv1 <= -ap_rr_pkg::sx32(v0);
      num1  <= $signed(mu_one) * $signed(v0);
      den1  <= {u0[31], u0} + {mu_two[31], mu_two};
    end
  end

  // cubic and coupling products
  ap_rr_pkg::wide_t ku, uv, t1, w, cub, dv;
  logic [127:0] ua_d;
  logic [127:0] um_d;
  logic [63:0]  uv_d;
  logic         t1clip_d;

  ap_rr_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_ku (
    .clk(clk), .en(en), .a(ap_rr_pkg::sx32(gain_k)), .b(ap_rr_pkg::sx32(u0)), .p(ku)
  );

  ap_rr_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_uv (
    .clk(clk), .en(en), .a(ap_rr_pkg::sx32(u0)), .b(ap_rr_pkg::sx32(v0)), .p(uv)
  );

  ap_rr_delay #(.W(128), .DEPTH(T_KU - T_PRE)) u_dly_ua (
    .clk(clk), .en(en), .d({uam1, ua1}), .q(ua_d)
  );

  ap_rr_delay #(.W(128), .DEPTH(T_T1 - T_PRE)) u_dly_um (
    .clk(clk), .en(en), .d({negv1, um1}), .q(um_d)
  );

  ap_rr_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_t1 (
    .clk(clk), .en(en), .a(ku.val), .b(ua_d[63:0]), .p(t1)
  );

  ap_rr_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_w (
    .clk(clk), .en(en), .a(ku.val), .b(ua_d[127:64]), .p(w)
  );

  ap_rr_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_cub (
    .clk(clk), .en(en), .a(t1.val), .b(um_d[63:0]), .p(cub)
  );

  ap_rr_delay #(.W(64), .DEPTH(T_CUB - T_KU)) u_dly_uv (
    .clk(clk), .en(en), .d(uv.val), .q(uv_d)
  );

  ap_rr_delay #(.W(1), .DEPTH(T_CUB - T_T1)) u_dly_t1c (
    .clk(clk), .en(en), .d(t1.clip), .q(t1clip_d)
  );

  // inner term and du
  ap_rr_pkg::wide_t inner_c, inner13, inner_d, du_c, du19, du_d;

  always_comb begin
    inner_c = ap_rr_pkg::sat_add(um_d[127:64], -w.val);
    du_c    = ap_rr_pkg::sat_add(-cub.val, -uv_d);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inner13.val  <= inner_c.val;
      inner13.clip <= inner_c.clip | w.clip;
      du19.val     <= du_c.val;
      du19.clip    <= du_c.clip | cub.clip | t1clip_d;
    end
  end

  ap_rr_delay #(.W(65), .DEPTH(T_EPS - T_INNER)) u_dly_inner (
    .clk(clk), .en(en), .d(inner13), .q(inner_d)
  );

  ap_rr_delay #(.W(65), .DEPTH(T_DV - T_DU)) u_dly_du (
    .clk(clk), .en(en), .d(du19), .q(du_d)
  );

  // ratio mu1*v/(u+mu2), rounded half away from zero
  logic [63:0] un1;
  logic [32:0] ud1;
  logic [63:0] n2;
  logic [33:0] d2;
  logic        qneg2, fault2;
  logic [1:0]  qf_d;
  logic [63:0] quo;

  always_comb begin
    un1 = num1[63] ? 64'(-num1) : num1;
    ud1 = den1[32] ? 33'(-den1) : den1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n2     <= {un1[62:0], 1'b0} + {31'b0, ud1};
      d2     <= {ud1, 1'b0};
      qneg2  <= num1[63] ^ den1[32];
      fault2 <= (den1 == '0);
    end
  end

  ap_rr_div u_div (
    .clk(clk), .en(en), .num(n2), .den(d2), .quo(quo)
  );

  ap_rr_delay #(.W(2), .DEPTH(T_Q - T_DIVIN)) u_dly_qf (
    .clk(clk), .en(en), .d({fault2, qneg2}), .q(qf_d)
  );

  logic signed [63:0] ratio67, eps68;
  logic               fault67, fault68, clip68;
  logic [1:0]         fc_d;
  ap_rr_pkg::wide_t   eps_c;

  assign eps_c = ap_rr_pkg::sat_add(ap_rr_pkg::sx32(eps_base), ratio67);

  always_ff @(posedge clk) begin
    if (en) begin
      ratio67 <= qf_d[0] ? 64'(-quo) : quo;
      fault67 <= qf_d[1];
      fault68 <= fault67;
      if (fault67) begin
        eps68  <= ap_rr_pkg::sx32(eps_base);
        clip68 <= 1'b0;
      end else begin
        eps68  <= eps_c.val;
        clip68 <= eps_c.clip;
      end
    end
  end

  ap_rr_qmul #(.FRAC_BITS(FRAC_BITS)) u_mul_dv (
    .clk(clk), .en(en), .a(eps68), .b(inner_d.val), .p(dv)
  );

  // inner_d sits at the same stage as eps68
  ap_rr_delay #(.W(2), .DEPTH(T_DV - T_EPS)) u_dly_fc (
    .clk(clk), .en(en), .d({fault68, clip68 | inner_d.clip}), .q(fc_d)
  );

  // output register
  ap_rr_pkg::word_t du32, dv32;

  always_comb begin
    du32 = ap_rr_pkg::clip32(du_d.val);
    dv32 = ap_rr_pkg::clip32(dv.val);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {6'b0,
                  du_d.clip | dv.clip | fc_d[0] | du32.clip | dv32.clip,
                  fc_d[1], dv32.val, du32.val};
    end
  end

endmodule

@@ rtl/ap_rr_chk.sv @@
// ----------------------------------------------------------------------------
// ap_rr_chk
// Port-level checks for the reaction-rate pipe, bound to the top level.
// ----------------------------------------------------------------------------
module ap_rr_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata
);

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // a stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output beat changed");

  // pipe takes no input while the output is stuck
  a_stall_in: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken during output stall");

  // empty output register never blocks the input
  a_free_in: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output");

  // padding bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[71:66] == 6'b0)
    else $error("nonzero padding in output beat");

endmodule

bind aliev_panfilov_reaction_rate ap_rr_chk u_ap_rr_chk (.*);

@@ bench/reaction_rate_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reaction_rate_checker
// Watches both streams and the coefficient port, computes the expected
// Aliev-Panfilov rates for every node taken in and compares each output beat.
// ----------------------------------------------------------------------------
module reaction_rate_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic                     saturated;
    logic                     divide_fault;
    logic signed [31:0]       recovery_rate;
    logic signed [31:0]       excitation_rate;
  } rates_t;

  localparam logic signed [127:0] BIG_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;

  logic signed [31:0] coef_k, coef_a, coef_e0, coef_m1, coef_m2;
  rates_t expected_rates[$];
  bit clipped;

  function automatic logic signed [63:0] clamp_wide(input logic signed [127:0] x);
    if (x > BIG_MAX) begin
      clipped = 1;
      return BIG_MAX[63:0];
    end
    if (x < -BIG_MAX) begin
      clipped = 1;
      return -BIG_MAX[63:0];
    end
    return x[63:0];
  endfunction

  // exact product, scaled down with rounding half away from zero
  function automatic logic signed [63:0] fx_mul(input logic signed [63:0] x,
                                                input logic signed [63:0] y);
    logic signed [127:0] p;
    logic [127:0] m;
    p = 128'(x) * 128'(y);
    m = p < 0 ? -p : p;
    m = (m + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return clamp_wide(p < 0 ? -$signed(m) : $signed(m));
  endfunction

  function automatic rates_t node_rates(input logic signed [31:0] u32,
                                        input logic signed [31:0] v32);
    logic signed [63:0] u, v, one, ku, cub, uv, du, w, inner, den, eps, dv, num, ratio;
    logic [127:0] un, ud, q;
    rates_t r;
    clipped = 0;
    u = u32;
    v = v32;
    one = 64'sd1 <<< FRAC_BITS;
    ku = fx_mul(coef_k, u);
    cub = fx_mul(fx_mul(ku, u - coef_a), u - one);
    uv = fx_mul(u, v);
    du = clamp_wide(-128'(cub) - 128'(uv));
    w = fx_mul(ku, u - coef_a - one);
    inner = clamp_wide(-128'(v) - 128'(w));
    den = u + coef_m2;
    r.divide_fault = (den == 0);
    if (den == 0) begin
      eps = coef_e0;
    end else begin
      num = 64'(coef_m1) * v;
      un = num < 0 ? -128'(num) : 128'(num);
      ud = den < 0 ? -128'(den) : 128'(den);
      q = (2 * un + ud) / (2 * ud);
      ratio = ((num < 0) != (den < 0)) ? -$signed(q[63:0]) : $signed(q[63:0]);
      eps = clamp_wide(128'(coef_e0) + 128'(ratio));
    end
    dv = fx_mul(eps, inner);
    r.excitation_rate = ap_rr_pkg::clip32(du).val;
    r.recovery_rate = ap_rr_pkg::clip32(dv).val;
    if (ap_rr_pkg::clip32(du).clip || ap_rr_pkg::clip32(dv).clip) clipped = 1;
    r.saturated = clipped;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] %s: got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    rates_t got, want;
    if (rst) begin
      coef_k <= 32'sd524288;
      coef_a <= 32'sd9830;
      coef_e0 <= 32'sd131;
      coef_m1 <= 32'sd13107;
      coef_m2 <= 32'sd19661;
      expected_rates.delete();
      fail_count = 0;
      pending_count = 0;
    end else begin
      if (s_tvalid && s_tready)
        expected_rates.push_back(node_rates(s_tdata[31:0], s_tdata[63:32]));
      if (m_tvalid && m_tready) begin
        got = m_tdata[65:0];
        if (m_tdata[71:66] != 0) report_mismatch("padding", 32'(m_tdata[71:66]), 0);
        if (expected_rates.size() == 0) begin
          report_mismatch("unexpected beat", got.excitation_rate, 0);
        end else begin
          want = expected_rates.pop_front();
          if (got.excitation_rate != want.excitation_rate)
            report_mismatch("excitation_rate", got.excitation_rate, want.excitation_rate);
          if (got.recovery_rate != want.recovery_rate)
            report_mismatch("recovery_rate", got.recovery_rate, want.recovery_rate);
          if (got.divide_fault != want.divide_fault)
            report_mismatch("divide_fault", 32'(got.divide_fault),
                            32'(want.divide_fault));
          if (got.saturated != want.saturated)
            report_mismatch("saturated", 32'(got.saturated), 32'(want.saturated));
        end
      end
      pending_count = expected_rates.size();
      if (cfg_wr_en) begin
        case (cfg_index)
          ap_rr_pkg::REG_GAIN_K:      coef_k <= cfg_data;
          ap_rr_pkg::REG_THRESHOLD_A: coef_a <= cfg_data;
          ap_rr_pkg::REG_EPS_BASE:    coef_e0 <= cfg_data;
          ap_rr_pkg::REG_MU_ONE:      coef_m1 <= cfg_data;
          ap_rr_pkg::REG_MU_TWO:      coef_m2 <= cfg_data;
          default: ;
        endcase
      end
    end
  end
endmodule

@@ bench/tb_aliev_panfilov_reaction_rate.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aliev_panfilov_reaction_rate
// Drives node values and coefficient sets through the reaction-rate pipe with
// bursty input, a stalling receiver and one long hold-off; the checker
// compares every output beat against its own computation.
// ----------------------------------------------------------------------------
module tb_aliev_panfilov_reaction_rate;

  localparam int LATENCY = 75;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, m_tready = 0, cfg_wr_en = 0;
  logic [63:0] s_tdata = 0;
  logic [2:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;
  logic s_tready, m_tvalid;
  logic [71:0] m_tdata;
  int fail_count, pending_count;
  int cycle_count = 0;
  bit long_hold = 0;

  always #6 clk = ~clk;

  aliev_panfilov_reaction_rate u_dut (.*);
  reaction_rate_checker u_checker (.*);

  // receiver stall pattern, with a long hold-off when asked
  always @(posedge clk) begin
    if (long_hold) m_tready <= 0;
    else if (cycle_count % 700 < 250) m_tready <= 1;
    else m_tready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("aliev_panfilov_reaction_rate: mismatch");
      $finish;
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'sh7FFF_FFFF;
      2: return 32'sh8000_0000;
      3: return $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
      default: return $urandom_range(0, 32'h0002_0000) - 32'h0000_4000;
    endcase
  endfunction

  // valid stays up after the beat; idle() drops it for a gap
  task automatic send_node(input logic [31:0] u, input logic [31:0] v);
    s_tvalid <= 1;
    s_tdata <= {v, u};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic idle(input int cycles);
    if (cycles > 0) begin
      s_tvalid <= 0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic write_coef(input logic [2:0] idx, input logic [31:0] val);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic random_nodes(input int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 20);
      while (burst > 0 && count > 0) begin
        if ($urandom_range(0, 9) == 0) send_node($urandom(), 32'($signed(-$urandom())));
        else send_node(pick_value(), pick_value());
        burst--;
        count--;
      end
      idle($urandom_range(0, 4));
    end
  endtask

  initial begin
    logic signed [31:0] m2;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // edges, zero divisor with default mu2, and ordinary operating points
    send_node(0, 0);
    send_node(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_node(32'h8000_0000, 32'h8000_0000);
    send_node(32'h7FFF_FFFF, 32'h8000_0000);
    send_node(32'h8000_0000, 32'h7FFF_FFFF);
    send_node(-32'sd19661, 32'h0001_0000);
    send_node(-32'sd19661, 0);
    send_node(32'h0001_0000, 32'h0000_8000);
    send_node(32'h0000_8000, 32'hFFFF_0000);
    send_node(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_node(32'h0000_2666, 32'h0000_1000);
    send_node(32'h0000_0001, 32'h8000_0000);
    random_nodes(60);
    // long receiver hold-off so the pipe fills and backs up
    long_hold <= 1;
    fork
      begin
        repeat (300) @(posedge clk);
        long_hold <= 0;
      end
      random_nodes(120);
    join
    drain();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_coef(ap_rr_pkg::REG_GAIN_K, 32'h7FFF_FFFF);
          write_coef(ap_rr_pkg::REG_THRESHOLD_A, 32'h8000_0000);
          write_coef(ap_rr_pkg::REG_EPS_BASE, 32'h7FFF_FFFF);
          write_coef(ap_rr_pkg::REG_MU_ONE, 32'h8000_0000);
          write_coef(ap_rr_pkg::REG_MU_TWO, 32'h7FFF_FFFF);
        end
        1: begin
          write_coef(ap_rr_pkg::REG_GAIN_K, 32'h8000_0000);
          write_coef(ap_rr_pkg::REG_THRESHOLD_A, 32'h7FFF_FFFF);
          write_coef(ap_rr_pkg::REG_EPS_BASE, 32'h8000_0000);
          write_coef(ap_rr_pkg::REG_MU_ONE, 32'h7FFF_FFFF);
          write_coef(ap_rr_pkg::REG_MU_TWO, 32'h8000_0000);
        end
        2: begin
          write_coef(ap_rr_pkg::REG_GAIN_K, 0);
          write_coef(ap_rr_pkg::REG_THRESHOLD_A, 0);
          write_coef(ap_rr_pkg::REG_EPS_BASE, 0);
          write_coef(ap_rr_pkg::REG_MU_ONE, 0);
          write_coef(ap_rr_pkg::REG_MU_TWO, 0);
        end
        default: begin
          write_coef(ap_rr_pkg::REG_GAIN_K, $urandom());
          write_coef(ap_rr_pkg::REG_THRESHOLD_A, $urandom_range(0, 32'h0001_0000));
          write_coef(ap_rr_pkg::REG_EPS_BASE, $urandom_range(0, 1000));
          write_coef(ap_rr_pkg::REG_MU_ONE, $urandom());
          write_coef(ap_rr_pkg::REG_MU_TWO, $urandom_range(0, 32'h0001_0000));
        end
      endcase
      cfg_wr_en <= 0;
      @(posedge clk);
      // zero divisor with the new mu2 (not when mu2 is the most negative value)
      m2 = u_checker.coef_m2;
      send_node(-m2, $urandom());
      random_nodes(60);
      drain();
    end
    if (fail_count == 0) $display("aliev_panfilov_reaction_rate: match");
    else $display("aliev_panfilov_reaction_rate: mismatch");
    $finish;
  end
endmodule
